@@ rtl/binomial_coefficient_macros.svh @@
// assertion helpers used by the checker file
`ifndef BINOMIAL_COEFFICIENT_MACROS_SVH
`define BINOMIAL_COEFFICIENT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define BC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define BC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bc_pkg.sv @@
// ----------------------------------------------------------------------------
// bc_pkg
// Shared constants, microcode types and the sequencer program for the
// binomial coefficient block.
// ----------------------------------------------------------------------------
package bc_pkg;

    localparam int IN_BITS          = 7;
    localparam int OUT_BITS         = 64;
    localparam int RESULT_BITS_DEF  = 64;
    localparam int INDEX_BITS_DEF   = 7;
    localparam int DIV_RADIX_BITS   = 4;
    localparam int PC_BITS          = 3;

    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_INIT,
        OP_MUL_SETUP,
        OP_MUL_STEP,
        OP_DIV_SETUP,
        OP_DIV_STEP,
        OP_NEXT,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_REQ,
        COND_SKIP,
        COND_MUL_MORE,
        COND_DIV_MORE,
        COND_ROUND_MORE,
        COND_OUT_FULL
    } t_cond;

    typedef struct packed {
        t_op                 op;
        t_cond               cond;
        logic [PC_BITS-1:0]  target;
    } t_ctrl;

    typedef struct packed {
        logic skip;
        logic mul_last;
        logic div_last;
        logic round_last;
    } t_stat;

    localparam logic [PC_BITS-1:0] STEP_ACCEPT    = 3'd0;
    localparam logic [PC_BITS-1:0] STEP_INIT      = 3'd1;
    localparam logic [PC_BITS-1:0] STEP_MUL_SETUP = 3'd2;
    localparam logic [PC_BITS-1:0] STEP_MUL_STEP  = 3'd3;
    localparam logic [PC_BITS-1:0] STEP_DIV_SETUP = 3'd4;
    localparam logic [PC_BITS-1:0] STEP_DIV_STEP  = 3'd5;
    localparam logic [PC_BITS-1:0] STEP_NEXT      = 3'd6;
    localparam logic [PC_BITS-1:0] STEP_FINISH    = 3'd7;

    // sequencer program; the last word falls through to the first by pc wrap
    function automatic t_ctrl rom_word(input logic [PC_BITS-1:0] pc);
        t_ctrl w;
        unique case (pc)
            STEP_ACCEPT:    w = '{op: OP_ACCEPT,    cond: COND_NO_REQ,     target: STEP_ACCEPT};
            STEP_INIT:      w = '{op: OP_INIT,      cond: COND_SKIP,       target: STEP_FINISH};
            STEP_MUL_SETUP: w = '{op: OP_MUL_SETUP, cond: COND_NEVER,      target: STEP_ACCEPT};
            STEP_MUL_STEP:  w = '{op: OP_MUL_STEP,  cond: COND_MUL_MORE,   target: STEP_MUL_STEP};
            STEP_DIV_SETUP: w = '{op: OP_DIV_SETUP, cond: COND_NEVER,      target: STEP_ACCEPT};
            STEP_DIV_STEP:  w = '{op: OP_DIV_STEP,  cond: COND_DIV_MORE,   target: STEP_DIV_STEP};
            STEP_NEXT:      w = '{op: OP_NEXT,      cond: COND_ROUND_MORE, target: STEP_MUL_SETUP};
            STEP_FINISH:    w = '{op: OP_FINISH,    cond: COND_OUT_FULL,   target: STEP_FINISH};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/bc_if.sv @@
// ----------------------------------------------------------------------------
// bc_req_if / bc_rsp_if
// Valid/ready channels for requests (n, k) and results (C(n,k), overflow).
// ----------------------------------------------------------------------------
interface bc_req_if;
    logic                        valid;
    logic                        ready;
    logic [bc_pkg::IN_BITS-1:0]  set_size;
    logic [bc_pkg::IN_BITS-1:0]  choose_count;

    modport source (output valid, output set_size, output choose_count, input ready);
    modport sink   (input valid, input set_size, input choose_count, output ready);
endinterface

interface bc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bc_pkg::OUT_BITS-1:0] coefficient;
    logic                        overflow;

    modport source (output valid, output coefficient, output overflow, input ready);
    modport sink   (input valid, input coefficient, input overflow, output ready);
endinterface

@@ rtl/bc_datapath.sv @@
// ----------------------------------------------------------------------------
// bc_datapath
// Wide accumulator with a shift-add multiplier and a radix-16 restoring
// divider by a small index, driven one control word at a time.
// ----------------------------------------------------------------------------
module bc_datapath #(
    parameter int RESULT_BITS = bc_pkg::RESULT_BITS_DEF,
    parameter int INDEX_BITS  = bc_pkg::INDEX_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bc_pkg::t_ctrl                i_ctrl,
    input  logic                         i_load,
    input  logic [bc_pkg::IN_BITS-1:0]   i_set_size,
    input  logic [bc_pkg::IN_BITS-1:0]   i_choose_count,
    output bc_pkg::t_stat                o_stat,
    output logic [bc_pkg::OUT_BITS-1:0]  o_coefficient,
    output logic                         o_overflow
);

    localparam int RB        = bc_pkg::DIV_RADIX_BITS;
    localparam int EXACT_W   = (1 << INDEX_BITS) + INDEX_BITS + 1;
    localparam int RAW_W     = (EXACT_W > RESULT_BITS) ? EXACT_W : RESULT_BITS + 1;
    localparam int DIV_STEPS = (RAW_W + RB - 1) / RB;
    localparam int ACC_W     = DIV_STEPS * RB;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    logic [INDEX_BITS-1:0] r_n, r_k, r_i, r_factor, r_rem;
    logic [INDEX_BITS-1:0] n_n, n_k, n_i, n_factor, n_rem;
    logic [ACC_W-1:0]      r_acc, r_prod, n_acc, n_prod;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    logic [ACC_W-1:0]      w_div_acc;
    logic [INDEX_BITS-1:0] w_div_rem;

    // four restoring division bits per cycle, quotient shifts in at the bottom
    always_comb begin
        logic [INDEX_BITS:0] v_trial;
        v_trial   = '0;
        w_div_acc = r_acc;
        w_div_rem = r_rem;
        for (int s = 0; s < RB; s++) begin
            v_trial   = {w_div_rem, w_div_acc[ACC_W-1]};
            w_div_acc = {w_div_acc[ACC_W-2:0], 1'b0};
            if (v_trial >= {1'b0, r_i}) begin
                w_div_rem    = INDEX_BITS'(v_trial - {1'b0, r_i});
                w_div_acc[0] = 1'b1;
            end else begin
                w_div_rem = v_trial[INDEX_BITS-1:0];
            end
        end
    end

    always_comb begin
        n_n      = r_n;
        n_k      = r_k;
        n_i      = r_i;
        n_factor = r_factor;
        n_rem    = r_rem;
        n_acc    = r_acc;
        n_prod   = r_prod;
        n_cnt    = r_cnt;
        unique case (i_ctrl.op)
            bc_pkg::OP_ACCEPT: begin
                if (i_load) begin
                    n_n = INDEX_BITS'(i_set_size);
                    n_k = INDEX_BITS'(i_choose_count);
                end
            end
            bc_pkg::OP_INIT: begin
                n_acc = (r_k <= r_n) ? ACC_W'(1) : '0;
                n_i   = INDEX_BITS'(1);
            end
            bc_pkg::OP_MUL_SETUP: begin
                n_prod   = '0;
                n_cnt    = '0;
                n_factor = r_n - r_k + r_i;
            end
            bc_pkg::OP_MUL_STEP: begin
                // msb-first shift and add
                n_prod   = {r_prod[ACC_W-2:0], 1'b0}
                         + (r_factor[INDEX_BITS-1] ? r_acc : '0);
                n_factor = {r_factor[INDEX_BITS-2:0], 1'b0};
                n_cnt    = r_cnt + CNT_W'(1);
            end
            bc_pkg::OP_DIV_SETUP: begin
                n_acc = r_prod;
                n_rem = '0;
                n_cnt = '0;
            end
            bc_pkg::OP_DIV_STEP: begin
                n_acc = w_div_acc;
                n_rem = w_div_rem;
                n_cnt = r_cnt + CNT_W'(1);
            end
            bc_pkg::OP_NEXT: begin
                n_i = r_i + INDEX_BITS'(1);
            end
            bc_pkg::OP_FINISH: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_k      <= n_k;
        r_i      <= n_i;
        r_factor <= n_factor;
        r_rem    <= n_rem;
        r_acc    <= n_acc;
        r_prod   <= n_prod;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_stat.skip       = (r_k == '0) || (r_k > r_n);
    assign o_stat.mul_last   = (r_cnt == CNT_W'(INDEX_BITS - 1));
    assign o_stat.div_last   = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_stat.round_last = (r_i == r_k);

    assign o_coefficient = bc_pkg::OUT_BITS'(r_acc[RESULT_BITS-1:0]);
    assign o_overflow    = |r_acc[ACC_W-1:RESULT_BITS];

endmodule

@@ rtl/binomial_coefficient.sv @@
// for k = 0 or k > n the init step jumps straight to the finish step;
// otherwise each of k rounds runs INDEX_BITS multiply steps and DIV_STEPS
// four-bit divide steps on the accumulator (7 and 34 at the defaults)
// throughput: one request at a time; the next is taken once the result
// sits in the output register, so a held result stalls only the following one
// reset: synchronous active-low i_rst_n returns the sequencer to its wait step
// ----------------------------------------------------------------------------
// binomial_coefficient
// Microcoded sequencer computing C(n,k) by the multiplicative rule over an
// exact wide accumulator, with an overflow flag above RESULT_BITS.
// ----------------------------------------------------------------------------
module binomial_coefficient #(
    parameter int RESULT_BITS = bc_pkg::RESULT_BITS_DEF,
    parameter int INDEX_BITS  = bc_pkg::INDEX_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bc_req_if.sink      i_req,
    bc_rsp_if.source    o_rsp
);

    logic [bc_pkg::PC_BITS-1:0]  r_pc, n_pc;
    bc_pkg::t_ctrl               w_ctrl;
    bc_pkg::t_stat               w_stat;
    logic                        w_accept;
    logic                        w_out_full;
    logic                        w_jump;
    logic                        w_emit;
    logic [bc_pkg::OUT_BITS-1:0] w_coef;
    logic                        w_ovf;

    logic                        r_out_valid;
    logic [bc_pkg::OUT_BITS-1:0] r_coef;
    logic                        r_ovf;

    assign w_ctrl      = bc_pkg::rom_word(r_pc);
    assign i_req.ready = (w_ctrl.op == bc_pkg::OP_ACCEPT);
    assign w_accept    = i_req.ready && i_req.valid;
    assign w_out_full  = r_out_valid && !o_rsp.ready;
    assign w_emit      = (w_ctrl.op == bc_pkg::OP_FINISH) && !w_out_full;

    always_comb begin
        unique case (w_ctrl.cond)
            bc_pkg::COND_NEVER:      w_jump = 1'b0;
            bc_pkg::COND_NO_REQ:     w_jump = !i_req.valid;
            bc_pkg::COND_SKIP:       w_jump = w_stat.skip;
            bc_pkg::COND_MUL_MORE:   w_jump = !w_stat.mul_last;
            bc_pkg::COND_DIV_MORE:   w_jump = !w_stat.div_last;
            bc_pkg::COND_ROUND_MORE: w_jump = !w_stat.round_last;
            bc_pkg::COND_OUT_FULL:   w_jump = w_out_full;
            default:                 w_jump = 1'b0;
        endcase
        n_pc = w_jump ? w_ctrl.target : r_pc + bc_pkg::PC_BITS'(1);
    end

    bc_datapath #(
        .RESULT_BITS (RESULT_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_load         (w_accept),
        .i_set_size     (i_req.set_size),
        .i_choose_count (i_req.choose_count),
        .o_stat         (w_stat),
        .o_coefficient  (w_coef),
        .o_overflow     (w_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_coef <= w_coef;
            r_ovf  <= w_ovf;
        end
        if (!i_rst_n) begin
            r_pc        <= bc_pkg::STEP_ACCEPT;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.coefficient = r_coef;
    assign o_rsp.overflow    = r_ovf;

endmodule

@@ rtl/bc_checker.sv @@
// ----------------------------------------------------------------------------
// bc_checker
// Port-level checks on the binomial coefficient block, bound to its top level.
// ----------------------------------------------------------------------------
`include "binomial_coefficient_macros.svh"

module bc_checker #(
    parameter int RESULT_BITS = bc_pkg::RESULT_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [bc_pkg::OUT_BITS-1:0]  i_rsp_coefficient
);

    logic w_req_take;
    logic w_high_clear;

    assign w_req_take   = i_req_valid && i_req_ready;
    assign w_high_clear = ((i_rsp_coefficient >> RESULT_BITS) == '0);

    // a waiting result keeps its value
    `BC_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_coefficient), "result dropped or changed while stalled")
    // the block works on one request at a time
    `BC_ASSERT_NEXT(a_one_at_a_time, w_req_take, !i_req_ready, "request taken while busy")
    // no result can appear the cycle after a request
    `BC_ASSERT_NEXT(a_min_latency, w_req_take, !$rose(i_rsp_valid), "result too early")
    // bits above the result width stay zero
    `BC_ASSERT_NOW(a_high_bits, i_rsp_valid, w_high_clear, "coefficient bits above width")

endmodule

bind binomial_coefficient bc_checker #(
    .RESULT_BITS (RESULT_BITS)
) u_bc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_coefficient (o_rsp.coefficient)
);
